// ===== sv/gray_blend_mode_compositor_defines.svh =====
`ifndef GRAY_BLEND_MODE_COMPOSITOR_DEFINES_SVH
`define GRAY_BLEND_MODE_COMPOSITOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define GBMC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gbmc assertion failed");

// Checked on every clock edge, reset included.
`define GBMC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("gbmc assertion failed");

`endif

// ===== sv/gbmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbmc_pkg;

  localparam logic [3:0] MODE_NORMAL   = 4'd0;
  localparam logic [3:0] MODE_MULTIPLY = 4'd1;
  localparam logic [3:0] MODE_SCREEN   = 4'd2;
  localparam logic [3:0] MODE_DARKEN   = 4'd3;
  localparam logic [3:0] MODE_LIGHTEN  = 4'd4;
  localparam logic [3:0] MODE_DIFF     = 4'd5;
  localparam logic [3:0] MODE_DODGE    = 4'd6;
  localparam logic [3:0] MODE_BURN     = 4'd7;
  localparam logic [3:0] MODE_SOFT     = 4'd8;

  typedef logic [7:0] sl_tab_t [256];

  function automatic sl_tab_t build_sl_tab();
    sl_tab_t tab;
    int d;
    int r;
    int c;
    int v;
    for (int cb = 0; cb < 256; cb++) begin
      if (cb <= 64) begin
        d = (16 * cb * cb * cb + 260100 * cb - 3060 * cb * cb) / 65025;
      end else begin
        v = 255 * cb;
        r = 0;
        for (int b = 128; b != 0; b = b / 2) begin
          c = r | b;
          if (c * c <= v) begin
            r = c;
          end
        end
        d = r;
      end
      if (d < cb) begin
        d = cb;
      end
      tab[cb] = 8'(d);
    end
    return tab;
  endfunction

  localparam sl_tab_t SL_TAB = build_sl_tab();

  function automatic logic [16:0] div255(input logic [23:0] x);
    logic [40:0] e;
    logic [16:0] q;
    logic [24:0] r;
    e = {1'b0, x, 16'd0} + {9'd0, x, 8'd0} + {17'd0, x};
    q = e[40:24];
    r = {1'b0, x} - ({q, 8'd0} - {8'd0, q});
    if (r >= 25'd255) begin
      q = q + 17'd1;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gbmc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbmc_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic      [7:0]  quo_o
);

  logic [15:0] rem_q [4];
  logic [7:0]  den_q [4];
  logic [7:0]  quo_q [4];
  logic [15:0] rem_d [4];
  logic [7:0]  quo_d [4];

  function automatic logic [23:0] div_step(input logic [15:0] rem, input logic [7:0] den,
                                           input logic [7:0] quo, input logic [2:0] idx);
    logic [22:0] cand;
    cand = {15'd0, den} << idx;
    if ({7'd0, rem} >= cand) begin
      rem = rem - cand[15:0];
      quo[idx] = 1'b1;
    end
    return {rem, quo};
  endfunction

  always_comb begin
    logic [23:0] s;
    logic [15:0] rem_src;
    logic [7:0]  den_src;
    logic [7:0]  quo_src;
    for (int k = 0; k < 4; k++) begin
      if (k == 0) begin
        rem_src = num_i;
        den_src = den_i;
        quo_src = 8'd0;
      end else begin
        rem_src = rem_q[k-1];
        den_src = den_q[k-1];
        quo_src = quo_q[k-1];
      end
      s = div_step(rem_src, den_src, quo_src, 3'(7 - 2 * k));
      s = div_step(s[23:8], den_src, s[7:0], 3'(6 - 2 * k));
      rem_d[k] = s[23:8];
      quo_d[k] = s[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      den_q[0] <= den_i;
      for (int k = 1; k < 4; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[3];

endmodule
`default_nettype wire

// ===== sv/gray_blend_mode_compositor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Gray blend-mode compositor: one pixel per clock unless a result waits on the output, fully
// pipelined over nine register stages. Stage 0 captures the pixel, stages 1-4 run the four
// steps of the radix-4 dodge/burn divider beside the other blend terms, stage 5 selects the
// blend value, and stages 6-8 form the weighted sum and its two chained divide-by-255 steps.
// Each transfer on the input channel yields exactly one mixed_value, presented on out_valid_o
// from stage 8. A result waiting on the output freezes the whole pipeline, input included,
// until it is taken. The blend mode is written through cfg_we_i / cfg_wdata_i (reset: screen)
// and is sampled per pixel as it enters.
`include "gray_blend_mode_compositor_defines.svh"
module gray_blend_mode_compositor (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] bottom_pixel_i,
  input  wire logic [7:0] top_pixel_i,
  input  wire logic [7:0] alpha_value_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] mixed_value_o
);

  logic [3:0] mode_q;
  logic [8:0] vld_q;
  logic       en;

  assign en = !vld_q[8] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= gbmc_pkg::MODE_SCREEN;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[7:0], in_valid_i};
      end
    end
  end

  // stage 0
  logic [7:0] cb0_q, cs0_q, a0_q;
  logic [3:0] md0_q;
  // stage 1
  logic [15:0] mulp1_q, scrp1_q, slhp1_q, slk1_q;
  logic [7:0]  u1_q, cb1_q, cs1_q, a1_q;
  logic [3:0]  md1_q;
  logic        ovf1_q;
  // stage 2
  logic [7:0]  bmul2_q, bscr2_q, cb2_q, cs2_q, a2_q;
  logic [8:0]  bslhi2_q;
  logic [23:0] slku2_q;
  logic [3:0]  md2_q;
  logic        ovf2_q;
  // stage 3
  logic [15:0] slq3_q;
  logic [7:0]  bmul3_q, bscr3_q, cb3_q, cs3_q;
  logic [8:0]  bslhi3_q;
  logic [15:0] w0_3_q, w1_3_q, w2_3_q;
  logic [3:0]  md3_q;
  logic        ovf3_q;
  // stage 4
  logic [7:0]  bsllo4_q, bmul4_q, bscr4_q, cb4_q, cs4_q;
  logic [8:0]  bslhi4_q;
  logic [15:0] w0_4_q, w1_4_q, w2_4_q;
  logic [3:0]  md4_q;
  logic        ovf4_q;
  // stage 5
  logic [7:0]  blend5_q, cb5_q, cs5_q;
  logic [15:0] w0_5_q, w1_5_q, w2_5_q;
  // stage 6
  logic [23:0] p0_6_q, p1_6_q, p2_6_q;
  // stage 7
  logic [15:0] q7_q;
  // stage 8
  logic [7:0]  out8_q;

  logic [7:0]  u0, t0, d0, dd0, m0, k0, den0, quo4, blend_d, na2;
  logic [15:0] num0;
  logic [16:0] sum6;

  function automatic logic [16:0] div255(input logic [23:0] x);
    return gbmc_pkg::div255(x);
  endfunction

  assign u0   = 8'd255 - cb0_q;
  assign t0   = 8'd255 - cs0_q;
  assign d0   = gbmc_pkg::SL_TAB[cb0_q];
  assign dd0  = d0 - cb0_q;
  assign m0   = 8'({cs0_q, 1'b0} - 9'd255);
  assign k0   = 8'(9'd255 - {cs0_q, 1'b0});
  assign num0 = (md0_q == gbmc_pkg::MODE_BURN) ? ({u0, 8'd0} - {8'd0, u0})
                                              : ({cb0_q, 8'd0} - {8'd0, cb0_q});
  assign den0 = (md0_q == gbmc_pkg::MODE_BURN) ? cs0_q : t0;
  assign na2  = 8'd255 - a2_q;

  gbmc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num0),
    .den_i (den0),
    .quo_o (quo4)
  );

  always_comb begin
    case (md4_q)
      gbmc_pkg::MODE_MULTIPLY: blend_d = bmul4_q;
      gbmc_pkg::MODE_SCREEN:   blend_d = bscr4_q;
      gbmc_pkg::MODE_DARKEN:   blend_d = (cb4_q < cs4_q) ? cb4_q : cs4_q;
      gbmc_pkg::MODE_LIGHTEN:  blend_d = (cb4_q > cs4_q) ? cb4_q : cs4_q;
      gbmc_pkg::MODE_DIFF:     blend_d = (cb4_q > cs4_q) ? cb4_q - cs4_q : cs4_q - cb4_q;
      gbmc_pkg::MODE_DODGE: begin
        if (cs4_q == 8'd255 || ovf4_q) begin
          blend_d = 8'd255;
        end else begin
          blend_d = quo4;
        end
      end
      gbmc_pkg::MODE_BURN: begin
        if (cs4_q == 8'd0 || ovf4_q) begin
          blend_d = 8'd0;
        end else begin
          blend_d = 8'd255 - quo4;
        end
      end
      gbmc_pkg::MODE_SOFT: begin
        if (!cs4_q[7]) begin
          blend_d = bsllo4_q;
        end else if (bslhi4_q[8]) begin
          blend_d = 8'd255;
        end else begin
          blend_d = bslhi4_q[7:0];
        end
      end
      default: blend_d = cs4_q;
    endcase
  end

  assign sum6 = div255(p0_6_q + p1_6_q + p2_6_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cb0_q <= bottom_pixel_i;
      cs0_q <= top_pixel_i;
      a0_q  <= alpha_value_i;
      md0_q <= mode_q;

      mulp1_q <= 16'(cb0_q) * 16'(cs0_q);
      scrp1_q <= 16'(u0) * 16'(t0);
      slhp1_q <= 16'(m0) * 16'(dd0);
      slk1_q  <= 16'(k0) * 16'(cb0_q);
      u1_q    <= u0;
      cb1_q   <= cb0_q;
      cs1_q   <= cs0_q;
      a1_q    <= a0_q;
      md1_q   <= md0_q;
      ovf1_q  <= {1'b0, num0} >= {1'b0, den0, 8'd0};

      bmul2_q  <= 8'(div255({8'd0, mulp1_q}));
      bscr2_q  <= 8'd255 - 8'(div255({8'd0, scrp1_q}));
      bslhi2_q <= {1'b0, cb1_q} + 9'(div255({8'd0, slhp1_q}));
      slku2_q  <= 24'(slk1_q) * 24'(u1_q);
      cb2_q    <= cb1_q;
      cs2_q    <= cs1_q;
      a2_q     <= a1_q;
      md2_q    <= md1_q;
      ovf2_q   <= ovf1_q;

      slq3_q   <= 16'(div255(slku2_q));
      w0_3_q   <= 16'(na2) * 16'(na2);
      w1_3_q   <= 16'(a2_q) * 16'(a2_q);
      w2_3_q   <= 16'(a2_q) * 16'(na2);
      bmul3_q  <= bmul2_q;
      bscr3_q  <= bscr2_q;
      bslhi3_q <= bslhi2_q;
      cb3_q    <= cb2_q;
      cs3_q    <= cs2_q;
      md3_q    <= md2_q;
      ovf3_q   <= ovf2_q;

      bsllo4_q <= cb3_q - 8'(div255({8'd0, slq3_q}));
      bmul4_q  <= bmul3_q;
      bscr4_q  <= bscr3_q;
      bslhi4_q <= bslhi3_q;
      cb4_q    <= cb3_q;
      cs4_q    <= cs3_q;
      w0_4_q   <= w0_3_q;
      w1_4_q   <= w1_3_q;
      w2_4_q   <= w2_3_q;
      md4_q    <= md3_q;
      ovf4_q   <= ovf3_q;

      blend5_q <= blend_d;
      cb5_q    <= cb4_q;
      cs5_q    <= cs4_q;
      w0_5_q   <= w0_4_q;
      w1_5_q   <= w1_4_q;
      w2_5_q   <= w2_4_q;

      p0_6_q <= 24'(w0_5_q) * 24'(cb5_q);
      p1_6_q <= 24'(w1_5_q) * 24'(cs5_q);
      p2_6_q <= 24'(w2_5_q) * 24'(blend5_q);

      q7_q <= sum6[15:0];

      out8_q <= 8'(div255({8'd0, q7_q}));
    end
  end

  assign mixed_value_o = out8_q;

  `GBMC_ASSERT(a_burn_edge, vld_q[4] && md4_q == gbmc_pkg::MODE_BURN && cs4_q == 8'd0 |-> blend_d == 8'd0)
  `GBMC_ASSERT(a_dodge_edge, vld_q[4] && md4_q == gbmc_pkg::MODE_DODGE && cs4_q == 8'd255 |-> blend_d == 8'd255)
  `GBMC_ASSERT(a_soft_low_bound, vld_q[4] && md4_q == gbmc_pkg::MODE_SOFT && !cs4_q[7] |-> bsllo4_q <= cb4_q)
  `GBMC_ASSERT(a_stall_hold, !en |=> $stable(vld_q) && $stable(out8_q))
  `GBMC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> vld_q == 9'd0)

endmodule
`default_nettype wire

// ===== tb/gray_blend_mode_compositor_tb.sv =====
`timescale 1ns / 1ps
module gray_blend_mode_compositor_tb;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] bottom_pixel_i;
  logic [7:0] top_pixel_i;
  logic [7:0] alpha_value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] mixed_value_o;

  gray_blend_mode_compositor dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .bottom_pixel_i(bottom_pixel_i),
    .top_pixel_i(top_pixel_i),
    .alpha_value_i(alpha_value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .mixed_value_o(mixed_value_o)
  );

  typedef struct {
    logic [3:0] mode;
    logic [7:0] cb;
    logic [7:0] cs;
    logic [7:0] a;
    int         known;
  } pixel_row_t;

  logic [3:0] mode_shadow;
  logic [7:0] pending_mix[$];
  int         fail_cnt;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_off_cycles;
  pixel_row_t dir_rows[$];

  function automatic logic [7:0] soft_root(input int v);
    int r;
    int c;
    r = 0;
    for (int bit_w = 128; bit_w != 0; bit_w = bit_w / 2) begin
      c = r | bit_w;
      if (c * c <= v) begin
        r = c;
      end
    end
    return 8'(r);
  endfunction

  function automatic logic [7:0] blend_of(input logic [3:0] mode, input logic [7:0] cb8,
                                          input logic [7:0] cs8);
    longint cb;
    longint cs;
    longint t;
    longint u;
    longint b;
    longint q;
    longint d;
    cb = cb8;
    cs = cs8;
    t = 255 - cs;
    u = 255 - cb;
    case (mode)
      gbmc_pkg::MODE_MULTIPLY: b = cb * cs / 255;
      gbmc_pkg::MODE_SCREEN:   b = 255 - u * t / 255;
      gbmc_pkg::MODE_DARKEN:   b = cb < cs ? cb : cs;
      gbmc_pkg::MODE_LIGHTEN:  b = cb > cs ? cb : cs;
      gbmc_pkg::MODE_DIFF:     b = cb > cs ? cb - cs : cs - cb;
      gbmc_pkg::MODE_DODGE: begin
        if (cs < 255) begin
          q = 255 * cb / t;
          b = q > 255 ? 255 : q;
        end else begin
          b = 255;
        end
      end
      gbmc_pkg::MODE_BURN: begin
        if (cs > 0) begin
          q = 255 * u / cs;
          b = 255 - (q > 255 ? 255 : q);
        end else begin
          b = 0;
        end
      end
      gbmc_pkg::MODE_SOFT: begin
        if (cs < 128) begin
          b = cb - ((255 - 2 * cs) * cb * u) / 65025;
        end else begin
          if (cb <= 64) begin
            d = (16 * cb * cb * cb + 260100 * cb - 3060 * cb * cb) / 65025;
          end else begin
            d = soft_root(int'(255 * cb));
          end
          if (d < cb) begin
            d = cb;
          end
          b = cb + ((2 * cs - 255) * (d - cb)) / 255;
        end
      end
      default: b = cs;
    endcase
    if (b > 255) begin
      b = 255;
    end
    if (b < 0) begin
      b = 0;
    end
    return 8'(b);
  endfunction

  function automatic logic [7:0] mix_of(input logic [3:0] mode, input logic [7:0] cb,
                                        input logic [7:0] cs, input logic [7:0] a);
    longint na;
    longint r;
    na = 255 - a;
    r = (na * na * cb + longint'(a) * a * cs + longint'(a) * na * blend_of(mode, cb, cs))
        / 65025;
    return r > 255 ? 8'd255 : 8'(r);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mix.size() == 0) begin
        $display("%0t: unexpected mixed_value %0d", $time, mixed_value_o);
        fail_cnt++;
      end else begin
        if (pending_mix[0] !== mixed_value_o) begin
          $display("%0t: mixed_value expected %0d actual %0d", $time, pending_mix[0],
                   mixed_value_o);
          fail_cnt++;
        end
        void'(pending_mix.pop_front());
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_mode(input logic [3:0] mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    mode_shadow = mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_mix.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] cb, input logic [7:0] cs, input logic [7:0] a,
                            input int known);
    logic [7:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    want = mix_of(mode_shadow, cb, cs, a);
    if (known >= 0 && want !== 8'(known)) begin
      $display("%0t: table row expected %0d predictor %0d", $time, known, want);
      fail_cnt++;
    end
    in_valid_i <= 1'b1;
    bottom_pixel_i <= cb;
    top_pixel_i <= cs;
    alpha_value_i <= a;
    do @(posedge clk_i); while (!in_ready_o);
    pending_mix.push_back(want);
  endtask

  function automatic logic [7:0] rand_px();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(128, 127));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0] m;
    fail_cnt = 0;
    hold_off_cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 48;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    bottom_pixel_i = '0;
    top_pixel_i = '0;
    alpha_value_i = '0;
    mode_shadow = gbmc_pkg::MODE_SCREEN;
    dir_rows = '{
      '{gbmc_pkg::MODE_SCREEN,   8'd0,   8'd0,   8'd255, 0},
      '{gbmc_pkg::MODE_SCREEN,   8'd255, 8'd0,   8'd255, 0},
      '{gbmc_pkg::MODE_SCREEN,   8'd200, 8'd77,  8'd0,   200},
      '{gbmc_pkg::MODE_NORMAL,   8'd10,  8'd250, 8'd255, 250},
      '{gbmc_pkg::MODE_NORMAL,   8'd170, 8'd85,  8'd128, -1},
      '{gbmc_pkg::MODE_MULTIPLY, 8'd255, 8'd255, 8'd255, 255},
      '{gbmc_pkg::MODE_MULTIPLY, 8'd100, 8'd0,   8'd255, 0},
      '{gbmc_pkg::MODE_DARKEN,   8'd90,  8'd200, 8'd255, 200},
      '{gbmc_pkg::MODE_LIGHTEN,  8'd90,  8'd200, 8'd255, 200},
      '{gbmc_pkg::MODE_DIFF,     8'd0,   8'd255, 8'd255, 255},
      '{gbmc_pkg::MODE_DIFF,     8'd30,  8'd200, 8'd99,  -1},
      '{gbmc_pkg::MODE_DODGE,    8'd0,   8'd255, 8'd255, 255},
      '{gbmc_pkg::MODE_DODGE,    8'd128, 8'd200, 8'd255, 200},
      '{gbmc_pkg::MODE_DODGE,    8'd40,  8'd100, 8'd180, -1},
      '{gbmc_pkg::MODE_BURN,     8'd255, 8'd0,   8'd255, 0},
      '{gbmc_pkg::MODE_BURN,     8'd10,  8'd50,  8'd255, 50},
      '{gbmc_pkg::MODE_BURN,     8'd200, 8'd150, 8'd170, -1},
      '{gbmc_pkg::MODE_SOFT,     8'd50,  8'd20,  8'd255, -1},
      '{gbmc_pkg::MODE_SOFT,     8'd64,  8'd200, 8'd255, -1},
      '{gbmc_pkg::MODE_SOFT,     8'd65,  8'd128, 8'd255, -1},
      '{gbmc_pkg::MODE_SOFT,     8'd255, 8'd255, 8'd200, -1},
      '{4'd9,                    8'd1,   8'd222, 8'd255, 222},
      '{4'd15,                   8'd99,  8'd33,  8'd255, 33}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (i != 0 && dir_rows[i].mode != mode_shadow) begin
        drain();
        write_mode(dir_rows[i].mode);
      end
      send_pixel(dir_rows[i].cb, dir_rows[i].cs, dir_rows[i].a, dir_rows[i].known);
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 37 : 0;
      for (int blk = 0; blk < 10; blk++) begin
        drain();
        m = (blk == 0) ? 4'd0 : (blk == 1) ? 4'd15 : 4'($urandom_range(15));
        if ($urandom_range(3) != 0 && m > 4'd8) begin
          m = 4'($urandom_range(8));
        end
        write_mode(m);
        if (ph == 2 && blk == 3) begin
          hold_off_cycles = 200;
        end
        repeat (33) begin
          send_pixel(rand_px(), rand_px(), rand_px(), -1);
        end
      end
    end
    drain();
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
